// File: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Constants, round table, command format and helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   // Command handed from the front end to the compression engine.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } cmd_type;

   typedef logic [31:0] word_type;

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   localparam word_type RoundConst [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;

   function automatic word_type ror(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: rtl/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input transfers, drops empty items, and queues commands.
// ----------------------------------------------------------------------------
module sha256_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sha256_pkg::cmd_type  in_cmd,
   output logic                 q_valid,
   input  logic                 q_ready,
   output sha256_pkg::cmd_type  q_cmd
);

   sha256_pkg::cmd_type mem_ff [sha256_pkg::QueueDepth];
   logic [sha256_pkg::QueueAw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [sha256_pkg::QueueAw:0]   cnt_ff, cnt_in;
   logic push, pop, useful;

   assign in_ready = (cnt_ff != sha256_pkg::QueueAw'(0) + (sha256_pkg::QueueAw+1)'(sha256_pkg::QueueDepth));
   assign useful   = in_cmd.byte_present | in_cmd.end_of_message;
   assign push     = in_valid & in_ready & useful;
   assign q_valid  = (cnt_ff != '0);
   assign pop      = q_valid & q_ready;
   assign q_cmd    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{sha256_pkg::QueueAw{1'b0}}, push} - {{sha256_pkg::QueueAw{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff < (sha256_pkg::QueueAw+1)'(sha256_pkg::QueueDepth)))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count mismatch");
`endif

endmodule

// File: rtl/sha256_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Buffers bytes, applies padding, runs 64 rounds per block, emits the digest.
// ----------------------------------------------------------------------------
module sha256_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  sha256_pkg::cmd_type  q_cmd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [31:0]          out_word,
   output logic [2:0]           out_index,
   output logic                 out_last
);

   typedef enum logic [2:0] {
      S_IDLE, S_ABSORB, S_PAD, S_ROUND, S_FINAL, S_EMIT
   } state_type;

   state_type state_ff;
   logic [31:0] blk_ff [16];  // block buffer, big-endian words
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [63:0] len_ff;
   logic        ending_ff;   // message end pending behind the current byte
   logic        marked_ff;   // the 0x80 pad byte has been written
   logic        lenblk_ff;   // the block being padded carries the length
   logic [31:0] hash_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  round_ff;
   logic [2:0]  idx_ff;
   logic [7:0]  pad_byte;
   logic [31:0] w_new, s1, ch, t1, s0, mj, t2;
   logic [3:0]  r4;

   assign q_ready = (state_ff == S_IDLE);

   always_comb begin
      if (!lenblk_ff || fill_ff < sha256_pkg::LenOffset) begin
         pad_byte = 8'h00;
      end else begin
         pad_byte = len_ff[{~fill_ff[2:0], 3'b000} +: 8];
      end
   end

   // Schedule word for this round; the first 16 come from the block buffer.
   always_comb begin
      r4 = round_ff[3:0];
      if (round_ff < 6'd16) begin
         w_new = blk_ff[r4];
      end else begin
         w_new = (sha256_pkg::ror(w_ff[r4 - 4'd2], 17) ^ sha256_pkg::ror(w_ff[r4 - 4'd2], 19)
                  ^ (w_ff[r4 - 4'd2] >> 10))
               + w_ff[r4 - 4'd7]
               + (sha256_pkg::ror(w_ff[r4 - 4'd15], 7) ^ sha256_pkg::ror(w_ff[r4 - 4'd15], 18)
                  ^ (w_ff[r4 - 4'd15] >> 3))
               + w_ff[r4];
      end
      s1 = sha256_pkg::ror(v_ff[4], 6) ^ sha256_pkg::ror(v_ff[4], 11)
         ^ sha256_pkg::ror(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + sha256_pkg::RoundConst[round_ff] + w_new;
      s0 = sha256_pkg::ror(v_ff[0], 2) ^ sha256_pkg::ror(v_ff[0], 13)
         ^ sha256_pkg::ror(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
   end

   assign out_valid = (state_ff == S_EMIT);
   assign out_word  = hash_ff[idx_ff];
   assign out_index = idx_ff;
   assign out_last  = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         ending_ff <= 1'b0;
         marked_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         round_ff  <= '0;
         idx_ff    <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::init_hash(3'(i));
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  ending_ff <= q_cmd.end_of_message;
                  if (q_cmd.byte_present) begin
                     blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= q_cmd.data_byte;
                     fill_ff         <= fill_ff + 6'd1;
                     bits_ff         <= bits_ff + 64'd8;
                     len_ff          <= bits_ff + 64'd8;
                     state_ff        <= (fill_ff == 6'd63) ? S_ROUND : S_ABSORB;
                  end else begin
                     len_ff   <= bits_ff;
                     state_ff <= S_ABSORB;
                  end
                  round_ff <= '0;
                  for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
               end
            end
            S_ABSORB: begin
               // Byte or end mark handled; start padding if the message ends here.
               if (ending_ff) begin
                  blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= sha256_pkg::PadByte;
                  fill_ff         <= fill_ff + 6'd1;
                  marked_ff       <= 1'b1;
                  // The length fits behind the pad byte only below offset 56.
                  lenblk_ff       <= (fill_ff < sha256_pkg::LenOffset);
                  state_ff        <= (fill_ff == 6'd63) ? S_ROUND : S_PAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_PAD: begin
               blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= pad_byte;
               fill_ff         <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               w_ff[round_ff[3:0]] <= w_new;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               for (int i = 0; i < 8; i++) begin
                  hash_ff[i] <= hash_ff[i] + v_ff[i];
                  v_ff[i]    <= hash_ff[i] + v_ff[i];
               end
               round_ff <= '0;
               idx_ff   <= '0;
               // A block filled by the last message byte still needs the pad
               // byte; a block without the length needs one more block.
               if (!ending_ff) begin
                  state_ff <= S_IDLE;
               end else if (!marked_ff) begin
                  state_ff <= S_ABSORB;
               end else if (!lenblk_ff) begin
                  lenblk_ff <= 1'b1;
                  state_ff  <= S_PAD;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_ready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::init_hash(3'(i));
                     fill_ff   <= '0;
                     bits_ff   <= '0;
                     ending_ff <= 1'b0;
                     marked_ff <= 1'b0;
                     lenblk_ff <= 1'b0;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && !out_last) |=> (out_valid && idx_ff == $past(idx_ff) + 3'd1))
      else $error("digest words out of order");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !q_ready)
      else $error("command taken while busy");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == 6'd63) |=> (state_ff == S_FINAL))
      else $error("round sequence broken");
`endif

endmodule

// File: rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Streams message bytes in and streams the eight digest words out.
// ----------------------------------------------------------------------------
// One message byte per input transfer. The engine takes a byte in S_IDLE
// and checks for the message end in S_ABSORB; the byte that fills a
// 64-byte block goes straight to compression, which runs 64 rounds and
// then the S_FINAL update. The engine takes no new byte until it is back
// in S_IDLE. A four-entry command queue takes input while a block
// compresses, until the queue is full. After end_of_message the engine
// writes the pad byte, pads the rest of the block at one byte per cycle,
// and compresses the one or two final blocks; the eight digest words then
// leave one per accepted cycle, most significant word first, and the hash
// returns to its initial value.
module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] data_byte, [8] byte_present, [15:9] zero
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast   // last_word
);

   sha256_pkg::cmd_type in_cmd, q_cmd;
   logic q_valid, q_ready;
   logic [31:0] word;
   logic [2:0]  index;

   assign in_cmd.data_byte      = req_tdata[7:0];
   assign in_cmd.byte_present   = req_tdata[8];
   assign in_cmd.end_of_message = req_tlast;

   sha256_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (in_cmd),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd)
   );

   sha256_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (word),
      .out_index (index),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, index, word};

endmodule
